@@ src/rn_pkg.sv @@
// Package for the fraction reducer: payload structs, divider handshake structs,
// sequencer state type and shared constants. Depends on nothing.

package rn_pkg;

    // Width of one fraction part. The result denominator is one bit narrower.
    localparam int DATA_W = 32;

    // Input item: signed numerator and signed denominator.
    typedef struct packed {
        logic signed [DATA_W-1:0] num_in;
        logic signed [DATA_W-1:0] den_in;
    } t_rn_in;

    // Result item: signed reduced numerator and nonnegative reduced denominator.
    typedef struct packed {
        logic signed [DATA_W-1:0] num_out;
        logic        [DATA_W-2:0] den_out;
    } t_rn_out;

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    // Response from the shared divider; quotient and remainder hold while idle.
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] rem;
    } t_div_rsp;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD_CHK,
        S_GCD_WAIT,
        S_RN_WAIT,
        S_RD_WAIT,
        S_DONE
    } t_rn_state;

endpackage

@@ src/rational_normalize_top.sv @@
// Top level of the fraction reducer: input handshake, sequencer, shared divider
// and output register. Depends on rn_pkg, rn_divider and rn_seq.
//
//   channel  direction  handshake              payload
//   in       input      i_in_valid/o_in_stall  i_in_data  (rn_pkg::t_rn_in)
//   out      output     o_out_valid/i_out_stall o_out_data (rn_pkg::t_rn_out)
//
// A zero part sends the sequencer straight to its done state, from which the result
// moves to the output register; otherwise it runs k Euclid remainder steps, each a
// compare state plus a divider pass, then the numerator and denominator divisions.
// The input stall drops once the result has left the sequencer for the output register.
// Reset is synchronous and clears the sequencer, divider control and output valid only.
// A stalled result holds in the output register while the next item is worked on.

module rational_normalize_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  rn_pkg::t_rn_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output rn_pkg::t_rn_out o_out_data
);
    import rn_pkg::*;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    t_rn_out  w_res_data;
    logic     w_res_valid;
    logic     w_res_take;
    logic     w_busy;
    logic     w_in_fire;

    logic     r_out_valid;
    t_rn_out  r_out_data;

    assign o_in_stall = w_busy;
    assign w_in_fire  = i_in_valid && !w_busy;
    assign w_res_take = !r_out_valid || !i_out_stall;

    rn_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (w_in_fire),
        .i_in_data   (i_in_data),
        .o_busy      (w_busy),
        .o_res_valid (w_res_valid),
        .o_res_data  (w_res_data),
        .i_res_take  (w_res_take),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp)
    );

    rn_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Output register: loads a finished result whenever it is empty or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take && w_res_valid) begin
            r_out_data <= w_res_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ src/rn_divider.sv @@
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on rn_pkg for the request and response structs.

module rn_divider (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rn_pkg::t_div_req i_req,
    output rn_pkg::t_div_rsp o_rsp
);
    import rn_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_div;

    logic [DATA_W:0]   n_shift;
    logic [DATA_W:0]   n_trial;
    logic              n_fit;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        n_shift = {r_rem, r_quo[DATA_W-1]};
        n_trial = n_shift - {1'b0, r_div};
        n_fit   = !n_trial[DATA_W];
    end

    // Control: busy for DATA_W steps after a start, then a one-cycle done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient register starts as the dividend and fills from the right.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_fit ? n_trial[DATA_W-1:0] : n_shift[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], n_fit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

@@ src/rn_seq.sv @@
// Sequencer of the fraction reducer: Euclid's loop and the two final divisions
// on the shared divider, plus sign and saturation handling. Depends on rn_pkg.

module rn_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  rn_pkg::t_rn_in   i_in_data,
    output logic             o_busy,
    output logic             o_res_valid,
    output rn_pkg::t_rn_out  o_res_data,
    input  logic             i_res_take,
    output rn_pkg::t_div_req o_div_req,
    input  rn_pkg::t_div_rsp i_div_rsp
);
    import rn_pkg::*;

    t_rn_state r_state, n_state;

    logic [DATA_W-1:0] r_a, n_a;
    logic [DATA_W-1:0] r_b, n_b;
    logic [DATA_W-1:0] r_g, n_g;
    logic [DATA_W-1:0] r_nmag, n_nmag;
    logic [DATA_W-1:0] r_dmag, n_dmag;
    logic [DATA_W-1:0] r_rn, n_rn;
    logic              r_neg, n_neg;
    logic              r_a_gt, n_a_gt;
    t_rn_out           r_res, n_res;

    logic              w_any_zero;
    logic              w_a_gt;
    logic [DATA_W-1:0] w_rd;
    logic [DATA_W-1:0] w_neg_rn;

    // Two's complement magnitude; the most negative value maps to 2^(DATA_W-1).
    function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign w_any_zero = (r_a == '0) || (r_b == '0);
    assign w_a_gt     = r_a > r_b;
    assign w_rd       = i_div_rsp.quo;
    assign w_neg_rn   = ~r_rn + 1'b1;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    if (i_in_data.num_in == '0 || i_in_data.den_in == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_GCD_CHK;
                    end
                end
            end
            S_GCD_CHK: begin
                n_state = w_any_zero ? S_RN_WAIT : S_GCD_WAIT;
            end
            S_GCD_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = S_GCD_CHK;
                end
            end
            S_RN_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = S_RD_WAIT;
                end
            end
            S_RD_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs: divider launches and handshake status.
    always_comb begin
        o_div_req   = '0;
        o_busy      = 1'b1;
        o_res_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
            end
            S_GCD_CHK: begin
                o_div_req.start = 1'b1;
                if (w_any_zero) begin
                    // The loop has ended: divide the numerator by the gcd.
                    o_div_req.dividend = r_nmag;
                    o_div_req.divisor  = r_a | r_b;
                end else if (w_a_gt) begin
                    o_div_req.dividend = r_a;
                    o_div_req.divisor  = r_b;
                end else begin
                    o_div_req.dividend = r_b;
                    o_div_req.divisor  = r_a;
                end
            end
            S_RD_WAIT: begin
                // Nothing to launch here; the denominator division runs already.
            end
            S_RN_WAIT: begin
                o_div_req.start    = i_div_rsp.done;
                o_div_req.dividend = r_dmag;
                o_div_req.divisor  = r_g;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_g    = r_g;
        n_nmag = r_nmag;
        n_dmag = r_dmag;
        n_rn   = r_rn;
        n_neg  = r_neg;
        n_a_gt = r_a_gt;
        n_res  = r_res;
        case (r_state)
            S_IDLE: begin
                n_nmag = mag_of(i_in_data.num_in);
                n_dmag = mag_of(i_in_data.den_in);
                n_a    = mag_of(i_in_data.num_in);
                n_b    = mag_of(i_in_data.den_in);
                n_neg  = i_in_data.num_in[DATA_W-1] ^ i_in_data.den_in[DATA_W-1];
                if (i_in_data.num_in == '0) begin
                    // Zero numerator reads as zero over one.
                    n_res.num_out = '0;
                    n_res.den_out = (DATA_W-1)'(1);
                end else begin
                    // Zero denominator reads as one over zero.
                    n_res.num_out = DATA_W'(1);
                    n_res.den_out = '0;
                end
            end
            S_GCD_CHK: begin
                n_a_gt = w_a_gt;
                n_g    = r_a | r_b;
            end
            S_GCD_WAIT: begin
                if (i_div_rsp.done) begin
                    if (r_a_gt) begin
                        n_a = i_div_rsp.rem;
                    end else begin
                        n_b = i_div_rsp.rem;
                    end
                end
            end
            S_RN_WAIT: begin
                if (i_div_rsp.done) begin
                    n_rn = i_div_rsp.quo;
                end
            end
            S_RD_WAIT: begin
                if (i_div_rsp.done) begin
                    // Saturate magnitudes that do not fit their field.
                    n_res.den_out = w_rd[DATA_W-1] ? '1 : w_rd[DATA_W-2:0];
                    if (r_neg) begin
                        n_res.num_out = w_neg_rn;
                    end else if (r_rn[DATA_W-1]) begin
                        n_res.num_out = {1'b0, {(DATA_W-1){1'b1}}};
                    end else begin
                        n_res.num_out = r_rn;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_g    <= n_g;
        r_nmag <= n_nmag;
        r_dmag <= n_dmag;
        r_rn   <= n_rn;
        r_neg  <= n_neg;
        r_a_gt <= n_a_gt;
        r_res  <= n_res;
    end

    assign o_res_data = r_res;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for rational_normalize_top: drives fraction items,
// predicts each reduced fraction and checks every result. Depends on rn_pkg.
`timescale 1ns / 1ps

module tb;

    import rn_pkg::*;

    localparam int          W        = DATA_W;
    localparam logic [63:0] WORD_M   = (64'd1 << W) - 64'd1;
    localparam logic [63:0] MAG_MAX  = (64'd1 << (W - 1)) - 64'd1;
    localparam logic [W-1:0] POS_MAX = MAG_MAX[W-1:0];
    localparam logic [W-1:0] NEG_MAX = ~MAG_MAX[W-1:0] + 1'b1;
    localparam int          N_RANDOM = 1425;
    localparam int          SETTLE_AT = 700;
    localparam int          HOLD_AT  = 300;
    localparam int          HOLD_CYC = 3000;
    localparam int          TAIL_CYC = 2000;
    localparam int          IDLE_LIMIT = 20000;

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_in_valid  = 1'b0;
    t_rn_in  i_in_data   = '0;
    logic    i_out_stall = 1'b0;
    logic    o_in_stall;
    logic    o_out_valid;
    t_rn_out o_out_data;

    // Items waiting to be sent, with a flag that makes the sender wait for all results.
    t_rn_in  fraction_q[$];
    bit      settle_q[$];
    // Reduced fractions predicted for accepted items, oldest first.
    t_rn_out reduced_q[$];

    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    int   got_cnt  = 0;
    int   err_cnt  = 0;
    int   idle_cnt = 0;
    int   tx_gap   = 0;
    int   tx_burst = 0;
    int   rx_wait  = 0;
    int   rx_burst = 0;
    int   hold_left = 0;

    rational_normalize_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Reduces one fraction to lowest terms with the sign on the numerator.
    function automatic t_rn_out reduce_fraction(t_rn_in f);
        logic [63:0] n, d, nmag, dmag, a, b, g, rn, rd;
        logic        neg;
        t_rn_out     r;
        n = {{(64-W){1'b0}}, f.num_in};
        d = {{(64-W){1'b0}}, f.den_in};
        if (n == 0) begin
            r.num_out = '0;
            r.den_out = (W-1)'(1);
        end else if (d == 0) begin
            r.num_out = W'(1);
            r.den_out = '0;
        end else begin
            neg  = n[W-1] ^ d[W-1];
            nmag = n[W-1] ? ((~n + 64'd1) & WORD_M) : n;
            dmag = d[W-1] ? ((~d + 64'd1) & WORD_M) : d;
            a = nmag;
            b = dmag;
            while (a != 0 && b != 0) begin
                if (a > b)
                    a = a % b;
                else
                    b = b % a;
            end
            g  = a + b;
            rn = nmag / g;
            rd = dmag / g;
            // A magnitude of 2^(W-1) only fits as a negative numerator.
            if (rd > MAG_MAX)
                rd = MAG_MAX;
            if (neg)
                rn = (~rn + 64'd1) & WORD_M;
            else if (rn > MAG_MAX)
                rn = MAG_MAX;
            r.num_out = rn[W-1:0];
            r.den_out = rd[W-2:0];
        end
        return r;
    endfunction

    // Any word of the field except the most negative value.
    function automatic logic [W-1:0] any_word();
        logic [W-1:0] v;
        v = $urandom;
        if (v == ~POS_MAX)
            v = NEG_MAX;
        return v;
    endfunction

    function automatic logic [W-1:0] with_sign(logic [63:0] mag);
        logic [W-1:0] v;
        v = mag[W-1:0];
        if ($urandom_range(0, 1))
            v = ~v + 1'b1;
        return v;
    endfunction

    // Random fraction: mostly small parts sharing a common factor, some full words.
    function automatic t_rn_in make_fraction();
        t_rn_in      f;
        int          kind;
        logic [63:0] lim, a, b, g;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            f.num_in = any_word();
            f.den_in = any_word();
        end else begin
            if (kind < 55)
                lim = 64'd255;
            else if (kind < 85)
                lim = 64'd65535;
            else
                lim = MAG_MAX;
            a = 64'($urandom_range(1, lim[31:0]));
            b = 64'($urandom_range(1, lim[31:0]));
            g = 64'($urandom_range(1, 1 << $urandom_range(0, 12)));
            if (a * g <= MAG_MAX && b * g <= MAG_MAX) begin
                a = a * g;
                b = b * g;
            end
            f.num_in = with_sign(a);
            f.den_in = with_sign(b);
        end
        if ($urandom_range(0, 24) == 0) begin
            if ($urandom_range(0, 1))
                f.num_in = '0;
            else
                f.den_in = '0;
        end
        return f;
    endfunction

    task automatic push_fraction(logic [W-1:0] num, logic [W-1:0] den, bit settle);
        t_rn_in f;
        f.num_in = num;
        f.den_in = den;
        fraction_q.push_back(f);
        settle_q.push_back(settle);
    endtask

    // Sender: offers the next item after a drawn gap and holds it while stalled.
    always @(negedge i_clk) begin : tx_drive
        logic nv;
        nv = i_in_valid && !in_fire;
        if (i_rst_n && !nv) begin
            if (in_fire) begin
                if (tx_burst > 0) begin
                    tx_burst--;
                    tx_gap = 0;
                end else if ($urandom_range(0, 30) == 0) begin
                    tx_burst = $urandom_range(10, 40);
                    tx_gap = 0;
                end else begin
                    tx_gap = $urandom_range(0, 10);
                end
            end else if (tx_gap > 0) begin
                tx_gap--;
            end
            if (tx_gap == 0 && fraction_q.size() > 0
                    && !(settle_q[0] && reduced_q.size() > 0)) begin
                i_in_data <= fraction_q.pop_front();
                void'(settle_q.pop_front());
                nv = 1'b1;
            end
        end
        i_in_valid <= nv;
    end

    // Receiver: stalls a drawn number of cycles per result, once for a long stretch.
    always @(negedge i_clk) begin : rx_drive
        if (i_rst_n) begin
            if (out_fire) begin
                if (got_cnt == HOLD_AT)
                    hold_left = HOLD_CYC;
                if (rx_burst > 0) begin
                    rx_burst--;
                    rx_wait = 0;
                end else if ($urandom_range(0, 30) == 0) begin
                    rx_burst = $urandom_range(10, 40);
                    rx_wait = 0;
                end else begin
                    rx_wait = $urandom_range(0, 10);
                end
            end else if (hold_left > 0) begin
                hold_left--;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_out_stall <= (hold_left > 0) || (rx_wait > 0);
        end
    end

    // Monitor: predicts accepted items, checks accepted results, watches for a hang.
    always @(posedge i_clk) begin : monitor
        logic    f_in, f_out;
        t_rn_out want;
        f_in  = i_rst_n && i_in_valid && !o_in_stall;
        f_out = i_rst_n && o_out_valid && !i_out_stall;
        if (f_in)
            reduced_q.push_back(reduce_fraction(i_in_data));
        if (f_out) begin
            got_cnt <= got_cnt + 1;
            if (reduced_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("ERROR: unexpected result num=%0d den=%0d",
                             o_out_data.num_out, o_out_data.den_out);
            end else begin
                want = reduced_q.pop_front();
                if (o_out_data.num_out !== want.num_out
                        || o_out_data.den_out !== want.den_out) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ERROR: result %0d expected %0d/%0d got %0d/%0d",
                                 got_cnt, want.num_out, want.den_out,
                                 o_out_data.num_out, o_out_data.den_out);
                end
            end
        end
        in_fire  <= f_in;
        out_fire <= f_out;
        if (f_in || f_out)
            idle_cnt = 0;
        else
            idle_cnt++;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("FAIL rational_normalize_top");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        // Zero parts, sign combinations, extremes and a long Euclid chain.
        push_fraction(0, 5, 0);
        push_fraction(0, 0, 0);
        push_fraction(0, -7, 0);
        push_fraction(5, 0, 0);
        push_fraction(-5, 0, 0);
        push_fraction(POS_MAX, 0, 0);
        push_fraction(POS_MAX, POS_MAX, 0);
        push_fraction(NEG_MAX, POS_MAX, 0);
        push_fraction(POS_MAX, NEG_MAX, 0);
        push_fraction(NEG_MAX, NEG_MAX, 0);
        push_fraction(POS_MAX, 1, 0);
        push_fraction(1, POS_MAX, 0);
        push_fraction(NEG_MAX, 1, 0);
        push_fraction(1, NEG_MAX, 0);
        push_fraction(-1, -1, 0);
        push_fraction(6, 4, 0);
        push_fraction(-6, 4, 0);
        push_fraction(6, -4, 0);
        push_fraction(-6, -4, 0);
        push_fraction(POS_MAX, POS_MAX - 1, 0);
        push_fraction(32'd1836311903, 32'd1134903170, 0);
        push_fraction(-32'd1134903170, 32'd1836311903, 0);
        push_fraction(1000, -10, 0);
        push_fraction(12, 12, 0);
        for (int i = 0; i < N_RANDOM; i++) begin
            fraction_q.push_back(make_fraction());
            settle_q.push_back(i == 0 || i == SETTLE_AT);
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (fraction_q.size() > 0 || i_in_valid || reduced_q.size() > 0)
            @(negedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);

        if (err_cnt == 0 && reduced_q.size() == 0) begin
            $display("PASS rational_normalize_top");
        end else begin
            $display("FAIL rational_normalize_top");
        end
        $finish;
    end

endmodule
